[design/gyro_bias_calibrate_median_denoise_macros.svh]
// assertion macros for the gyro bias calibration block
`ifndef GYRO_BIAS_CALIBRATE_MEDIAN_DENOISE_MACROS_SVH
`define GYRO_BIAS_CALIBRATE_MEDIAN_DENOISE_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define GBC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define GBC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[design/gbc_pkg.sv]
// package for the gyro bias calibration block: types, constants and helpers
`timescale 1ns / 1ps
`default_nettype none
package gbc_pkg;
  localparam int SampleBits = 24;
  localparam int Window     = 5;
  localparam int Axes       = 3;
  localparam int ShrinkShift = 20;
  localparam int WinIdxBits = $clog2(Window);
  localparam int FillBits   = $clog2(Window + 1);
  localparam int AxIdxBits  = 2;
  localparam int WideBits   = SampleBits + 2;

  typedef logic signed [SampleBits-1:0] sample_t;
  typedef logic signed [WideBits-1:0]   wide_t;

  typedef enum logic [2:0] {
    CFG_DROP_COUNT  = 3'd0,
    CFG_STILL_LIMIT = 3'd1,
    CFG_MAX_ERR     = 3'd2,
    CFG_STABLE      = 3'd3,
    CFG_NZ_CAL      = 3'd4,
    CFG_NZ_UNCAL    = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RANGE,
    ST_CORRECT,
    ST_MEDIAN,
    ST_SHRINK,
    ST_OUT
  } state_t;

  // control group sent from the sequencer to the median unit
  typedef struct packed {
    logic                  start;
    logic [AxIdxBits-1:0]  axis;
    logic [FillBits-1:0]   fill;
  } med_ctrl_t;

  function automatic wide_t sx(input sample_t v);
    return wide_t'(v);
  endfunction
endpackage
`default_nettype wire

[design/gbc_median.sv]
// median unit: holds the sample windows and ranks one window by counting
`timescale 1ns / 1ps
`default_nettype none
module gbc_median (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          wr_en,
  input  wire [gbc_pkg::AxIdxBits-1:0] wr_axis,
  input  wire [gbc_pkg::WinIdxBits-1:0] wr_idx,
  input  wire gbc_pkg::sample_t        wr_data,
  input  wire gbc_pkg::med_ctrl_t      ctrl,
  output logic                         done,
  output gbc_pkg::sample_t             median
);
  import gbc_pkg::*;

  sample_t win_x_r [Window];
  sample_t win_y_r [Window];
  sample_t win_z_r [Window];

  logic                  busy_r, busy_nxt;
  logic [WinIdxBits-1:0] cand_r, cand_nxt;
  logic [AxIdxBits-1:0]  axis_r;
  logic [FillBits-1:0]   fill_r;
  logic                  done_r, done_nxt;
  sample_t               median_r, median_nxt;
  sample_t               row [Window];
  logic [FillBits-1:0]   less_cnt, le_cnt, rank;
  sample_t               c;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      case (wr_axis)
        2'd0: win_x_r[wr_idx] <= wr_data;
        2'd1: win_y_r[wr_idx] <= wr_data;
        default: win_z_r[wr_idx] <= wr_data;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < Window; i++) begin
      case (axis_r)
        2'd0: row[i] = win_x_r[i];
        2'd1: row[i] = win_y_r[i];
        default: row[i] = win_z_r[i];
      endcase
    end
  end

  // candidate is the lower median when fewer than rank+1 lie below it
  // and at least rank+1 lie at or below it
  always_comb begin
    c = row[cand_r];
    less_cnt = '0;
    le_cnt = '0;
    for (int i = 0; i < Window; i++) begin
      if (FillBits'(i) < fill_r) begin
        if (row[i] < c) less_cnt = less_cnt + 1'b1;
        if (row[i] <= c) le_cnt = le_cnt + 1'b1;
      end
    end
    rank = FillBits'((fill_r - 1'b1) >> 1);
  end

  always_comb begin
    busy_nxt = busy_r;
    cand_nxt = cand_r;
    done_nxt = 1'b0;
    median_nxt = median_r;
    if (ctrl.start) begin
      busy_nxt = 1'b1;
      cand_nxt = '0;
    end else if (busy_r) begin
      if (less_cnt <= rank && le_cnt > rank) begin
        median_nxt = c;
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cand_nxt = cand_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cand_r   <= cand_nxt;
    median_r <= median_nxt;
    if (ctrl.start) begin
      axis_r <= ctrl.axis;
      fill_r <= ctrl.fill;
    end
  end

  assign done = done_r;
  assign median = median_r;
endmodule
`default_nettype wire

[design/gyro_bias_calibrate_median_denoise.sv]
// gyro bias calibration with median denoise, top level and sequencer
// a dropped word is taken in idle and the input stays ready; any other word passes
// through the check (while calibrating), range (until stable), correct, median, shrink
// and out steps; the median ranks one candidate per cycle for each axis
// no new word is taken before the current one is done; the input is ready again once the
// result is registered, and a stalled result holds the next word in its last step
// rst_n is synchronous: registers return to their reset values, window
// entries stay unwritten and are tracked by a fill count.
`timescale 1ns / 1ps
`default_nettype none
module gyro_bias_calibrate_median_denoise (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire [71:0] in_tdata,   // axis_x, axis_y, axis_z
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [71:0] out_tdata, // out_x, out_y, out_z
  output logic [1:0] out_tuser,  // is_calibrated, is_still
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire [2:0]  cfg_index,
  input  wire [22:0] cfg_data
);
  import gbc_pkg::*;

  logic [7:0]  drop_count_r;
  logic [22:0] still_limit_r, max_err_r, nz_cal_r, nz_uncal_r;
  logic [9:0]  stable_needed_r;

  logic [7:0]  drop_counter_r;
  logic        cal_r;
  logic [9:0]  stable_r;
  sample_t     min_r [Axes];
  sample_t     max_r [Axes];
  sample_t     bias_r [Axes];
  sample_t     s_r [Axes];
  logic [FillBits-1:0]   fill_r;
  logic [WinIdxBits-1:0] widx_r;
  logic        ok_r, still_r;
  logic [AxIdxBits-1:0] ax_r;
  logic        med_wait_r;
  state_t      state_r, state_nxt;
  logic        out_valid_r;
  logic [71:0] out_data_r;
  logic [1:0]  out_user_r;

  sample_t     cur;
  wide_t       curw, absw, diff, span, nmin, nmax;
  logic        md_done;
  sample_t     md_val;
  med_ctrl_t   mc;
  logic        wr_en;
  sample_t     corr;
  logic [22:0] nz;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tuser = out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drop_count_r <= 8'd5;
      still_limit_r <= 23'd65536;
      max_err_r <= 23'd3277;
      stable_needed_r <= 10'd100;
      nz_cal_r <= 23'd1311;
      nz_uncal_r <= 23'd6554;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DROP_COUNT:  drop_count_r <= cfg_data[7:0];
        CFG_STILL_LIMIT: still_limit_r <= cfg_data;
        CFG_MAX_ERR:     max_err_r <= cfg_data;
        CFG_STABLE:      stable_needed_r <= cfg_data[9:0];
        CFG_NZ_CAL:      nz_cal_r <= cfg_data;
        CFG_NZ_UNCAL:    nz_uncal_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // shared datapath on the current axis
  always_comb begin
    cur  = s_r[ax_r];
    curw = sx(cur);
    absw = curw[WideBits-1] ? -curw : curw;
    nmin = (curw < sx(min_r[ax_r])) ? curw : sx(min_r[ax_r]);
    nmax = (curw > sx(max_r[ax_r])) ? curw : sx(max_r[ax_r]);
    span = nmax - nmin;
    diff = curw - sx(bias_r[ax_r]);
    if (diff > wide_t'({1'b0, {(SampleBits-1){1'b1}}})) corr = {1'b0, {(SampleBits-1){1'b1}}};
    else if (diff < -wide_t'({1'b1, {(SampleBits-1){1'b0}}}))
      corr = {1'b1, {(SampleBits-1){1'b0}}};
    else corr = diff[SampleBits-1:0];
    nz = cal_r ? nz_cal_r : nz_uncal_r;
  end

  assign wr_en = (state_r == ST_CORRECT);
  assign mc = '{start: (state_r == ST_MEDIAN) && !med_wait_r, axis: ax_r, fill: fill_r};

  gbc_median u_median (
    .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_axis(ax_r), .wr_idx(widx_r),
    .wr_data(corr), .ctrl(mc), .done(md_done), .median(md_val)
  );

  logic last_ax;
  assign last_ax = (ax_r == AxIdxBits'(Axes - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_tvalid && in_tready && drop_counter_r >= drop_count_r)
        state_nxt = cal_r ? ST_CORRECT : ST_CHECK;
      ST_CHECK: begin
        // not still: restart and skip straight to correction
        if (absw >= wide_t'(still_limit_r)) state_nxt = ST_CORRECT;
        else if (last_ax)
          state_nxt = (stable_r < stable_needed_r) ? ST_RANGE : ST_CORRECT;
      end
      ST_RANGE: if (last_ax) state_nxt = ST_CORRECT;
      ST_CORRECT: if (last_ax) state_nxt = ST_MEDIAN;
      ST_MEDIAN: if (med_wait_r && md_done && last_ax) state_nxt = ST_SHRINK;
      ST_SHRINK: if (last_ax) state_nxt = ST_OUT;
      ST_OUT: if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drop_counter_r <= '0;
      cal_r <= 1'b0;
      stable_r <= '0;
      fill_r <= '0;
      widx_r <= '0;
      ax_r <= '0;
      med_wait_r <= 1'b0;
      out_valid_r <= 1'b0;
      ok_r <= 1'b1;
      still_r <= 1'b1;
      for (int a = 0; a < Axes; a++) begin
        bias_r[a] <= '0;
        min_r[a] <= sample_t'({1'b0, 23'd65536});
        max_r[a] <= -sample_t'({1'b0, 23'd65536});
      end
    end else begin
      if (out_valid_r && out_tready && state_r != ST_OUT) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          ax_r <= '0;
          ok_r <= 1'b1;
          still_r <= 1'b1;
          if (in_tvalid && in_tready) begin
            if (drop_counter_r < drop_count_r) drop_counter_r <= drop_counter_r + 1'b1;
            s_r[0] <= in_tdata[23:0];
            s_r[1] <= in_tdata[47:24];
            s_r[2] <= in_tdata[71:48];
          end
        end
        ST_CHECK: begin
          if (absw >= wide_t'(still_limit_r)) begin
            cal_r <= 1'b0;
            stable_r <= '0;
            for (int a = 0; a < Axes; a++) begin
              bias_r[a] <= '0;
              min_r[a] <= sample_t'(still_limit_r);
              max_r[a] <= -sample_t'(still_limit_r);
            end
            ax_r <= '0;
          end else if (last_ax) begin
            ax_r <= '0;
          end else ax_r <= ax_r + 1'b1;
          if (last_ax && absw < wide_t'(still_limit_r)
              && stable_r >= stable_needed_r) begin
            for (int a = 0; a < Axes; a++)
              bias_r[a] <= sample_t'((sx(max_r[a]) + sx(min_r[a])) >>> 1);
            cal_r <= 1'b1;
          end
        end
        ST_RANGE: begin
          if (span > wide_t'(max_err_r)) ok_r <= 1'b0;
          if (last_ax && !(ok_r && !(span > wide_t'(max_err_r)))) begin
            // span too wide on some axis: restart
            ax_r <= '0;
            stable_r <= '0;
            for (int a = 0; a < Axes; a++) begin
              bias_r[a] <= '0;
              min_r[a] <= sample_t'(still_limit_r);
              max_r[a] <= -sample_t'(still_limit_r);
            end
          end else begin
            min_r[ax_r] <= nmin[SampleBits-1:0];
            max_r[ax_r] <= nmax[SampleBits-1:0];
            if (last_ax) begin
              ax_r <= '0;
              stable_r <= stable_r + 1'b1;
            end else ax_r <= ax_r + 1'b1;
          end
        end
        ST_CORRECT: begin
          if (last_ax) begin
            ax_r <= '0;
            if (fill_r < FillBits'(Window)) fill_r <= fill_r + 1'b1;
          end else ax_r <= ax_r + 1'b1;
        end
        ST_MEDIAN: begin
          if (!med_wait_r) med_wait_r <= 1'b1;
          else if (md_done) begin
            med_wait_r <= 1'b0;
            s_r[ax_r] <= md_val;
            if (last_ax) begin
              ax_r <= '0;
              widx_r <= (widx_r == WinIdxBits'(Window - 1)) ? '0 : widx_r + 1'b1;
            end else ax_r <= ax_r + 1'b1;
          end
        end
        ST_SHRINK: begin
          if (absw >= wide_t'(nz)) still_r <= 1'b0;
          if (last_ax) ax_r <= '0;
          else ax_r <= ax_r + 1'b1;
        end
        ST_OUT: begin
          // hold here while the previous word is still waiting
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            for (int a = 0; a < Axes; a++)
              out_data_r[a*SampleBits +: SampleBits] <=
                still_r ? (s_r[a] >>> ShrinkShift) : s_r[a];
            out_user_r <= {still_r, cal_r};
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

[design/gbc_checker.sv]
// port-level checker for the gyro bias calibration block
`timescale 1ns / 1ps
`default_nettype none
`include "gyro_bias_calibrate_median_denoise_macros.svh"
module gbc_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [71:0] out_tdata,
  input wire [1:0]  out_tuser
);
  `GBC_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result word dropped or changed while stalled")
  `GBC_ASSERT_NXT(a_user_hold, clk, rst_n, out_tvalid && !out_tready, $stable(out_tuser), "result flags changed while stalled")
  `GBC_ASSERT_NXT(a_reset_idle, clk, 1'b1, !rst_n, !out_tvalid, "result valid right after reset")
endmodule
bind gyro_bias_calibrate_median_denoise gbc_checker u_gbc_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);
`default_nettype wire

[tb/sv/gyro_bias_calibrate_median_denoise_checker.sv]
// checker for the gyro bias calibration block: watches both streams, predicts and compares
`timescale 1ns / 1ps
module gyro_bias_calibrate_median_denoise_checker (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  input  wire        in_tready,
  input  wire [71:0] in_tdata,
  input  wire        out_tvalid,
  input  wire        out_tready,
  input  wire [71:0] out_tdata,
  input  wire [1:0]  out_tuser,
  input  wire        cfg_valid,
  input  wire        cfg_ready,
  input  wire [2:0]  cfg_index,
  input  wire [22:0] cfg_data,
  output int         fail_count,
  output int         pending
);
  import gbc_pkg::*;

  typedef struct packed {
    logic [71:0] data;
    logic [1:0]  user;
  } gyro_word_t;

  gyro_word_t expected_words[$];

  logic [7:0]  drop_count_r;
  logic [22:0] still_limit_r, max_err_r, nz_cal_r, nz_uncal_r;
  logic [9:0]  stable_needed_r;

  logic [7:0]  dropped;
  logic        calibrated;
  logic [9:0]  stable_cnt;
  longint      rate_min[3], rate_max[3], bias[3];
  longint      history[3][5];
  int          fill, wr_idx;

  assign pending = expected_words.size();

  function automatic longint shift_floor(longint v, int s);
    return v >>> s;
  endfunction

  task automatic restart_cal();
    calibrated = 1'b0;
    stable_cnt = '0;
    for (int a = 0; a < 3; a++) begin
      bias[a] = 0;
      rate_min[a] = still_limit_r;
      rate_max[a] = -longint'(still_limit_r);
    end
  endtask

  task automatic report(string what, logic [73:0] got, logic [73:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  task automatic predict_word(logic [71:0] d);
    longint s[3];
    longint t[5];
    longint v, nz, hi, lo;
    logic   still, ok, took;
    int     n, j;
    gyro_word_t w;
    if (dropped < drop_count_r) begin
      dropped++;
      return;
    end
    for (int a = 0; a < 3; a++) s[a] = longint'($signed(d[a*24 +: 24]));
    if (!calibrated) begin
      took = 1'b0;
      still = 1'b1;
      for (int a = 0; a < 3; a++)
        if ((s[a] < 0 ? -s[a] : s[a]) >= still_limit_r) still = 1'b0;
      if (!still) restart_cal();
      else if (stable_cnt < stable_needed_r) begin
        ok = 1'b1;
        for (int a = 0; a < 3; a++) begin
          if (s[a] < rate_min[a]) rate_min[a] = s[a];
          if (s[a] > rate_max[a]) rate_max[a] = s[a];
          if (rate_max[a] - rate_min[a] > max_err_r) ok = 1'b0;
        end
        if (ok) stable_cnt++;
        else restart_cal();
      end else begin
        for (int a = 0; a < 3; a++) bias[a] = shift_floor(rate_max[a] + rate_min[a], 1);
        took = 1'b1;
      end
      calibrated = took;
    end
    hi = 64'sd8388607;
    lo = -64'sd8388608;
    if (fill < 5) fill++;
    for (int a = 0; a < 3; a++) begin
      v = s[a] - bias[a];
      history[a][wr_idx] = v > hi ? hi : (v < lo ? lo : v);
      n = fill;
      for (int i = 0; i < n; i++) t[i] = history[a][i];
      for (int i = 1; i < n; i++) begin
        v = t[i];
        j = i;
        while (j > 0 && t[j-1] > v) begin
          t[j] = t[j-1];
          j--;
        end
        t[j] = v;
      end
      s[a] = t[(n-1)/2];
    end
    wr_idx = (wr_idx + 1) % 5;
    nz = calibrated ? nz_cal_r : nz_uncal_r;
    still = 1'b1;
    for (int a = 0; a < 3; a++)
      if ((s[a] < 0 ? -s[a] : s[a]) >= nz) still = 1'b0;
    if (still)
      for (int a = 0; a < 3; a++) s[a] = shift_floor(s[a], ShrinkShift);
    for (int a = 0; a < 3; a++) w.data[a*24 +: 24] = s[a][23:0];
    w.user = {still, calibrated};
    expected_words.push_back(w);
  endtask

  always @(posedge clk) begin
    gyro_word_t w;
    if (!rst_n) begin
      drop_count_r = 8'd5;
      still_limit_r = 23'd65536;
      max_err_r = 23'd3277;
      stable_needed_r = 10'd100;
      nz_cal_r = 23'd1311;
      nz_uncal_r = 23'd6554;
      dropped = '0;
      fill = 0;
      wr_idx = 0;
      restart_cal();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_DROP_COUNT:  drop_count_r = cfg_data[7:0];
          CFG_STILL_LIMIT: still_limit_r = cfg_data;
          CFG_MAX_ERR:     max_err_r = cfg_data;
          CFG_STABLE:      stable_needed_r = cfg_data[9:0];
          CFG_NZ_CAL:      nz_cal_r = cfg_data;
          CFG_NZ_UNCAL:    nz_uncal_r = cfg_data;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0)
          report("unexpected word", {out_tuser, out_tdata}, '0);
        else begin
          w = expected_words.pop_front();
          for (int a = 0; a < 3; a++)
            if (out_tdata[a*24 +: 24] !== w.data[a*24 +: 24])
              report($sformatf("axis %0d", a), 74'(out_tdata[a*24 +: 24]),
                     74'(w.data[a*24 +: 24]));
          if (out_tuser[0] !== w.user[0])
            report("is_calibrated", 74'(out_tuser[0]), 74'(w.user[0]));
          if (out_tuser[1] !== w.user[1])
            report("is_still", 74'(out_tuser[1]), 74'(w.user[1]));
        end
      end
      if (in_tvalid && in_tready) predict_word(in_tdata);
    end
  end
endmodule

[tb/sv/tb_gyro_bias_calibrate_median_denoise.sv]
// testbench top for the gyro bias calibration block: stimulus, stalls and verdict
`timescale 1ns / 1ps
module tb_gyro_bias_calibrate_median_denoise;
  import gbc_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic [71:0] in_tdata = '0;
  logic        out_tready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [22:0] cfg_data = '0;
  wire         in_tready, out_tvalid, cfg_ready;
  wire  [71:0] out_tdata;
  wire  [1:0]  out_tuser;
  int          fail_count, pending;
  int          idle_cycles = 0;
  bit          hold_off = 1'b0;

  always #1 clk = ~clk;

  gyro_bias_calibrate_median_denoise u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  gyro_bias_calibrate_median_denoise_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // receiver stall pattern, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_off) out_tready <= 1'b0;
    else case ($urandom_range(0, 3))
      0: out_tready <= 1'b0;
      default: out_tready <= 1'b1;
    endcase
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("[gyro_bias_calibrate_median_denoise] ERROR");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [22:0] v);
    cfg_index <= idx;
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // one sample; valid stays high across back-to-back words
  task automatic send_sample(logic [71:0] d, bit keep);
    in_tdata <= d;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    if (!keep) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
  endtask

  function automatic logic [23:0] near_rate(int spread);
    return 24'($signed($urandom_range(0, 2*spread)) - spread);
  endfunction

  function automatic logic [71:0] make_sample(int kind);
    logic [71:0] d;
    for (int a = 0; a < 3; a++)
      case (kind)
        0: d[a*24 +: 24] = 24'($urandom);
        1: d[a*24 +: 24] = near_rate(1200) + 24'd300;
        2: d[a*24 +: 24] = near_rate(40);
        default: d[a*24 +: 24] = $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
      endcase
    return d;
  endfunction

  task automatic send_burst(int count, int kind_mix);
    int left;
    int kind;
    left = count;
    while (left > 0) begin
      int burst;
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && left > 0; i++) begin
        kind = $urandom_range(0, 9) < kind_mix ? 0 : $urandom_range(1, 2);
        if ($urandom_range(0, 40) == 0) kind = 3;
        send_sample(make_sample(kind), i + 1 < burst && left > 1);
        left--;
      end
      repeat ($urandom_range(0, 1) ? 0 : $urandom_range(1, 30)) @(negedge clk);
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: default settings, dropped words, extremes and near zero
    send_sample({24'h7fffff, 24'h800000, 24'h000000}, 1'b0);
    repeat (4) send_sample(make_sample(2), 1'b0);
    send_sample({24'h800000, 24'h7fffff, 24'hffffff}, 1'b0);
    send_sample({24'h000001, 24'hffffff, 24'h000000}, 1'b0);
    send_sample({24'h00ffff, 24'h010000, 24'hff0000}, 1'b0);
    repeat (6) send_sample(make_sample(1), 1'b0);
    wait_drained();

    // quick calibration: short stable count, no drop
    write_reg(CFG_DROP_COUNT, 23'd0);
    write_reg(CFG_STABLE, 23'd1);
    write_reg(CFG_MAX_ERR, 23'd3000);
    write_reg(CFG_NZ_CAL, 23'd2000);
    write_reg(CFG_NZ_UNCAL, 23'd0);
    repeat (6) send_sample(make_sample(2), 1'b0);
    send_sample({24'h7fffff, 24'h7fffff, 24'h7fffff}, 1'b0);
    wait_drained();

    // extreme registers
    write_reg(CFG_STILL_LIMIT, 23'h7fffff);
    write_reg(CFG_MAX_ERR, 23'h7fffff);
    write_reg(CFG_STABLE, 23'd1023);
    write_reg(CFG_NZ_CAL, 23'h7fffff);
    write_reg(CFG_NZ_UNCAL, 23'h7fffff);
    write_reg(CFG_DROP_COUNT, 23'd255);
    send_burst(300, 5);
    wait_drained();

    write_reg(CFG_DROP_COUNT, 23'd0);
    write_reg(CFG_STILL_LIMIT, 23'd1);
    write_reg(CFG_MAX_ERR, 23'd0);
    write_reg(CFG_NZ_CAL, 23'd0);
    write_reg(CFG_NZ_UNCAL, 23'd50);
    send_burst(60, 3);
    wait_drained();

    // realistic settings: most words are still, so calibration happens
    write_reg(CFG_STILL_LIMIT, 23'd65536);
    write_reg(CFG_MAX_ERR, 23'd3277);
    write_reg(CFG_STABLE, 23'd20);
    write_reg(CFG_NZ_CAL, 23'd1311);
    write_reg(CFG_NZ_UNCAL, 23'd6554);
    send_burst(250, 1);

    // long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      send_burst(30, 1);
    join
    wait_drained();

    write_reg(CFG_STABLE, 23'd3);
    write_reg(CFG_MAX_ERR, 23'd500);
    send_burst(250, 2);
    in_tvalid <= 1'b0;
    wait_drained();

    if (fail_count == 0)
      $display("[gyro_bias_calibrate_median_denoise] OK");
    else
      $display("[gyro_bias_calibrate_median_denoise] ERROR");
    $finish;
  end
endmodule
